FILE: hw/rtl/vcmm_pkg.sv
// ----------------------------------------------------------------------------
// vcmm_pkg: shared types and constants of the volume cell min/max block
// Default geometry, fixed field widths, register indexes and the control
// group that travels from the front stage to the merge stage.
// ----------------------------------------------------------------------------
package vcmm_pkg;

  localparam int CELL_BITS_DEF = 4;
  localparam int MAX_AXIS_DEF  = 512;

  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 15;
  localparam int SIZE_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 48;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic valid;      // a row segment end waits in the merge stage
    logic emit;       // that segment completes its cell
    logic first_row;  // first row of the cell: no slab entry to merge
    logic fwd;        // slab entry comes from the write of the previous beat
  } s1_ctl_t;

  function automatic sample_t umin(input sample_t a, input sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sample_t umax(input sample_t a, input sample_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: hw/rtl/volume_cell_min_max.sv
// Path: an accepted beat passes the front register, then the merge and the result
// register, before its cell result shows on out_tvalid.
// Throughput: one input beat per cycle, set by the single slab RAM port pair
// with write-to-read forwarding; only a stalled result with a cell pending holds.
// Reset (rst_n low, synchronous): position at origin, sizes 512, pipe empty;
// slab RAM keeps its contents and is written before it is read.
// ----------------------------------------------------------------------------
// volume_cell_min_max: per-cell min/max of a raster voxel stream
// Keeps row segment min/max in registers, merges it into a slab RAM entry
// per cell and emits index, min and max when a cell's last voxel arrives.
// ----------------------------------------------------------------------------
module volume_cell_min_max
  import vcmm_pkg::*;
#(
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int MAX_AXIS  = MAX_AXIS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SAMPLE_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                 in_tuser,   // [0] first_voxel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata   // [14:0] cell_index, [30:15] cell_min,
                                           // [46:31] cell_max, [47] zero
);

  localparam int CELL     = 1 << CELL_BITS;
  localparam int POS_W    = $clog2(MAX_AXIS);
  localparam int SX_W     = POS_W + 1;
  localparam int CW       = (POS_W > CELL_BITS) ? (POS_W - CELL_BITS) : 1;
  localparam int GRID_MAX = (MAX_AXIS + CELL - 1) >> CELL_BITS;
  localparam int GW       = $clog2(GRID_MAX + 1);
  localparam int DEPTH    = GRID_MAX * GRID_MAX;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [SX_W-1:0]   sx, sy, sz;
  logic [GW-1:0]     gx, gy;

  function automatic logic [SX_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    if (v == '0) begin
      return SX_W'(1);
    end
    if (32'(v) > 32'(MAX_AXIS)) begin
      return SX_W'(MAX_AXIS);
    end
    return SX_W'(v);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RESET;
      size_y_r <= SIZE_RESET;
      size_z_r <= SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    sx = eff_size(size_x_r);
    sy = eff_size(size_y_r);
    sz = eff_size(size_z_r);
    gx = GW'((32'(sx) + 32'(CELL - 1)) >> CELL_BITS);
    gy = GW'((32'(sy) + 32'(CELL - 1)) >> CELL_BITS);
  end

  s1_ctl_t               s1_ctl;
  logic [AW-1:0]         s1_si;
  sample_t               s1_run_min, s1_run_max, s1_fwd_min, s1_fwd_max;
  logic [2*GW-1:0]       s1_gxy;
  logic [CW-1:0]         s1_cz;
  logic                  adv, ram_re, ram_we;
  sample_t               wr_min, wr_max;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [2*SAMPLE_W-1:0] ram_rdata, ram_wdata;

  vcmm_front #(
    .CELL_BITS (CELL_BITS),
    .MAX_AXIS  (MAX_AXIS),
    .POS_W     (POS_W),
    .SX_W      (SX_W),
    .CW        (CW),
    .GW        (GW),
    .AW        (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_sample    (in_tdata),
    .in_first     (in_tuser),
    .sx           (sx),
    .sy           (sy),
    .sz           (sz),
    .gx           (gx),
    .gy           (gy),
    .adv          (adv),
    .wr_min       (wr_min),
    .wr_max       (wr_max),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .s1_ctl_r     (s1_ctl),
    .s1_si_r      (s1_si),
    .s1_run_min_r (s1_run_min),
    .s1_run_max_r (s1_run_max),
    .s1_fwd_min_r (s1_fwd_min),
    .s1_fwd_max_r (s1_fwd_max),
    .s1_gxy_r     (s1_gxy),
    .s1_cz_r      (s1_cz)
  );

  vcmm_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_slab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vcmm_merge #(
    .GW (GW),
    .CW (CW),
    .AW (AW)
  ) u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_ctl_r     (s1_ctl),
    .s1_si_r      (s1_si),
    .s1_run_min_r (s1_run_min),
    .s1_run_max_r (s1_run_max),
    .s1_fwd_min_r (s1_fwd_min),
    .s1_fwd_max_r (s1_fwd_max),
    .s1_gxy_r     (s1_gxy),
    .s1_cz_r      (s1_cz),
    .ram_rdata    (ram_rdata),
    .adv          (adv),
    .wr_min       (wr_min),
    .wr_max       (wr_max),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

FILE: hw/rtl/vcmm_ram.sv
// ----------------------------------------------------------------------------
// vcmm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module vcmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/vcmm_front.sv
// ----------------------------------------------------------------------------
// vcmm_front: raster position, row segment min/max and slab lookup
// Tracks the voxel position, folds each sample into the running segment
// min/max and, at a segment end, issues the slab read and loads the merge
// stage register.
// ----------------------------------------------------------------------------
module vcmm_front
  import vcmm_pkg::*;
#(
  parameter int CELL_BITS = CELL_BITS_DEF,
  parameter int MAX_AXIS  = MAX_AXIS_DEF,
  parameter int POS_W     = $clog2(MAX_AXIS),
  parameter int SX_W      = POS_W + 1,
  parameter int CW        = (POS_W > CELL_BITS) ? (POS_W - CELL_BITS) : 1,
  parameter int GW        = 2,
  parameter int AW        = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sample_t           in_sample,
  input  logic              in_first,
  input  logic [SX_W-1:0]   sx,
  input  logic [SX_W-1:0]   sy,
  input  logic [SX_W-1:0]   sz,
  input  logic [GW-1:0]     gx,
  input  logic [GW-1:0]     gy,
  input  logic              adv,
  input  sample_t           wr_min,
  input  sample_t           wr_max,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  output s1_ctl_t           s1_ctl_r,
  output logic [AW-1:0]     s1_si_r,
  output sample_t           s1_run_min_r,
  output sample_t           s1_run_max_r,
  output sample_t           s1_fwd_min_r,
  output sample_t           s1_fwd_max_r,
  output logic [2*GW-1:0]   s1_gxy_r,
  output logic [CW-1:0]     s1_cz_r
);

  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0] pos_x_nxt, pos_y_nxt, pos_z_nxt;
  sample_t          run_min_r, run_max_r, run_min_nxt, run_max_nxt;

  logic [POS_W-1:0] px0, py0, pz0, px, py, pz;
  logic [SX_W-1:0]  px1, py1, pz1;
  logic [CELL_BITS-1:0] xo, yo, zo;
  logic             seg_end, last_y, last_z, first_row, accept;
  logic [CW-1:0]    cx, cy, cz;
  logic [AW-1:0]    si;
  logic [2*GW-1:0]  gxy;
  s1_ctl_t          s1_ctl_nxt;

  assign in_tready = !s1_ctl_r.valid || adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // restart on a first voxel, wrap a counter left beyond a shrunk size
    px0 = in_first ? '0 : pos_x_r;
    py0 = in_first ? '0 : pos_y_r;
    pz0 = in_first ? '0 : pos_z_r;
    px  = (SX_W'(px0) >= sx) ? '0 : px0;
    py  = (SX_W'(py0) >= sy) ? '0 : py0;
    pz  = (SX_W'(pz0) >= sz) ? '0 : pz0;
    px1 = SX_W'(px) + SX_W'(1);
    py1 = SX_W'(py) + SX_W'(1);
    pz1 = SX_W'(pz) + SX_W'(1);
    xo  = CELL_BITS'(px);
    yo  = CELL_BITS'(py);
    zo  = CELL_BITS'(pz);

    if (xo == '0) begin
      run_min_nxt = in_sample;
      run_max_nxt = in_sample;
    end else begin
      run_min_nxt = umin(run_min_r, in_sample);
      run_max_nxt = umax(run_max_r, in_sample);
    end

    seg_end   = (&xo) || (px1 >= sx);
    last_y    = (&yo) || (py1 >= sy);
    last_z    = (&zo) || (pz1 >= sz);
    first_row = (yo == '0) && (zo == '0);

    cx  = CW'(px >> CELL_BITS);
    cy  = CW'(py >> CELL_BITS);
    cz  = CW'(pz >> CELL_BITS);
    si  = AW'(32'(cy) * 32'(gx) + 32'(cx));
    gxy = gx * gy;

    // advance the raster position
    pos_x_nxt = POS_W'(px1);
    pos_y_nxt = py;
    pos_z_nxt = pz;
    if (px1 >= sx) begin
      pos_x_nxt = '0;
      pos_y_nxt = POS_W'(py1);
      if (py1 >= sy) begin
        pos_y_nxt = '0;
        pos_z_nxt = (pz1 >= sz) ? '0 : POS_W'(pz1);
      end
    end

    s1_ctl_nxt.valid     = seg_end;
    s1_ctl_nxt.emit      = last_y && last_z;
    s1_ctl_nxt.first_row = first_row;
    s1_ctl_nxt.fwd       = s1_ctl_r.valid && adv && (s1_si_r == si);
  end

  assign ram_re    = accept && seg_end;
  assign ram_raddr = si;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      pos_z_r   <= '0;
      run_min_r <= '1;
      run_max_r <= '0;
      s1_ctl_r  <= '0;
    end else if (accept) begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      pos_z_r   <= pos_z_nxt;
      run_min_r <= run_min_nxt;
      run_max_r <= run_max_nxt;
      s1_ctl_r  <= s1_ctl_nxt;
    end else if (adv) begin
      s1_ctl_r.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_si_r      <= si;
      s1_run_min_r <= run_min_nxt;
      s1_run_max_r <= run_max_nxt;
      s1_fwd_min_r <= wr_min;
      s1_fwd_max_r <= wr_max;
      s1_gxy_r     <= gxy;
      s1_cz_r      <= cz;
    end
  end

endmodule

FILE: hw/rtl/vcmm_merge.sv
// ----------------------------------------------------------------------------
// vcmm_merge: slab merge, write-back and result register
// Merges a finished row segment with its slab entry, writes the entry back
// and loads the result register when the segment completes a cell.
// ----------------------------------------------------------------------------
module vcmm_merge
  import vcmm_pkg::*;
#(
  parameter int GW = 2,
  parameter int CW = 1,
  parameter int AW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  s1_ctl_t          s1_ctl_r,
  input  logic [AW-1:0]    s1_si_r,
  input  sample_t          s1_run_min_r,
  input  sample_t          s1_run_max_r,
  input  sample_t          s1_fwd_min_r,
  input  sample_t          s1_fwd_max_r,
  input  logic [2*GW-1:0]  s1_gxy_r,
  input  logic [CW-1:0]    s1_cz_r,
  input  logic [2*SAMPLE_W-1:0] ram_rdata,
  output logic             adv,
  output sample_t          wr_min,
  output sample_t          wr_max,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [2*SAMPLE_W-1:0] ram_wdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  localparam int IDXF_W = CW + 2 * GW + AW + 1;

  sample_t           base_min, base_max;
  logic [IDXF_W-1:0] idx_full;
  logic              out_free, load;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  sample_t           out_min_r, out_max_r;

  always_comb begin
    base_min = s1_ctl_r.fwd ? s1_fwd_min_r : ram_rdata[SAMPLE_W-1:0];
    base_max = s1_ctl_r.fwd ? s1_fwd_max_r : ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
    if (s1_ctl_r.first_row) begin
      wr_min = s1_run_min_r;
      wr_max = s1_run_max_r;
    end else begin
      wr_min = umin(s1_run_min_r, base_min);
      wr_max = umax(s1_run_max_r, base_max);
    end
    idx_full = IDXF_W'(s1_cz_r) * IDXF_W'(s1_gxy_r) + IDXF_W'(s1_si_r);
  end

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = !s1_ctl_r.emit || out_free;
  assign ram_we    = s1_ctl_r.valid && adv;
  assign ram_waddr = s1_si_r;
  assign ram_wdata = {wr_max, wr_min};
  assign load      = ram_we && s1_ctl_r.emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx_r <= IDX_W'(idx_full);
      out_min_r <= wr_min;
      out_max_r <= wr_max;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_max_r, out_min_r, out_idx_r});

endmodule

FILE: tb/sv/tb_volume_cell_min_max.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_volume_cell_min_max: self-checking bench for the cell min/max block
// Streams voxel beats through several volume geometries, predicts every
// completed cell (index, min, max) and compares each result beat against it.
// Sender and receiver idle at random. One long receiver hold forces the
// block to stall its input.
// ----------------------------------------------------------------------------
module tb_volume_cell_min_max;
  import vcmm_pkg::*;

  localparam int          HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_BEATS = 1000;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    sample_t          lo;
    sample_t          hi;
  } cell_t;

  // Tracks raster position, row segment and slab min/max; queues finished cells.
  class cell_range_tracker;
    logic [SIZE_W-1:0] size_q [3];
    int unsigned       pos_x, pos_y, pos_z;
    sample_t           slab_lo [1024];
    sample_t           slab_hi [1024];
    sample_t           seg_lo, seg_hi;
    cell_t             expected_cells [$];
    int unsigned       errors;
    int unsigned       cells_seen;

    function new();
      foreach (size_q[i]) size_q[i] = SIZE_RESET;
      foreach (slab_lo[i]) begin
        slab_lo[i] = '0;
        slab_hi[i] = '0;
      end
      pos_x = 0;
      pos_y = 0;
      pos_z = 0;
      seg_lo = '1;
      seg_hi = '0;
      errors = 0;
      cells_seen = 0;
    endfunction

    function int unsigned axis_len(input logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_AXIS_DEF) return MAX_AXIS_DEF;
      return v;
    endfunction

    function void set_size(input cfg_reg_t r, input logic [SIZE_W-1:0] v);
      size_q[int'(r)] = v;
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction

    function void note_voxel(input sample_t s, input logic first);
      int unsigned sx, sy, sz, gx, gy, cx, cy, cz, si, idx;
      sample_t     lo, hi;
      logic        last_y, last_z;
      cell_t       c;
      sx = axis_len(size_q[int'(REG_SIZE_X)]);
      sy = axis_len(size_q[int'(REG_SIZE_Y)]);
      sz = axis_len(size_q[int'(REG_SIZE_Z)]);
      gx = (sx + 15) >> CELL_BITS_DEF;
      gy = (sy + 15) >> CELL_BITS_DEF;
      if (first) begin
        pos_x = 0;
        pos_y = 0;
        pos_z = 0;
      end
      // wrap any counter left beyond a shrunk size
      if (pos_x >= sx) pos_x = 0;
      if (pos_y >= sy) pos_y = 0;
      if (pos_z >= sz) pos_z = 0;

      if ((pos_x & 15) == 0) begin
        seg_lo = s;
        seg_hi = s;
      end else begin
        seg_lo = (s < seg_lo) ? s : seg_lo;
        seg_hi = (s > seg_hi) ? s : seg_hi;
      end

      if ((pos_x & 15) == 15 || pos_x + 1 >= sx) begin
        cx = pos_x >> CELL_BITS_DEF;
        cy = pos_y >> CELL_BITS_DEF;
        cz = pos_z >> CELL_BITS_DEF;
        si = cy * gx + cx;
        if (si >= 1024) si = 0;
        lo = seg_lo;
        hi = seg_hi;
        // merge with the slab entry unless this is the cell's first row
        if (!((pos_y & 15) == 0 && (pos_z & 15) == 0)) begin
          lo = (slab_lo[si] < lo) ? slab_lo[si] : lo;
          hi = (slab_hi[si] > hi) ? slab_hi[si] : hi;
        end
        slab_lo[si] = lo;
        slab_hi[si] = hi;
        last_y = ((pos_y & 15) == 15) || (pos_y + 1 >= sy);
        last_z = ((pos_z & 15) == 15) || (pos_z + 1 >= sz);
        if (last_y && last_z) begin
          idx = cz * gx * gy + cy * gx + cx;
          c.index = idx[IDX_W-1:0];
          c.lo = lo;
          c.hi = hi;
          expected_cells.push_back(c);
        end
      end

      pos_x++;
      if (pos_x >= sx) begin
        pos_x = 0;
        pos_y++;
        if (pos_y >= sy) begin
          pos_y = 0;
          pos_z++;
          if (pos_z >= sz) pos_z = 0;
        end
      end
    endfunction

    task report(input string what);
      errors++;
      if (errors <= 50) $display("[%0t] cell error: %s", $time, what);
    endtask

    task check_cell(input logic [OUT_W-1:0] beat);
      cell_t want;
      cells_seen++;
      if (expected_cells.size() == 0) begin
        report($sformatf("unexpected cell beat, index %0d", beat[IDX_W-1:0]));
        return;
      end
      want = expected_cells.pop_front();
      if (beat[IDX_W-1:0] !== want.index)
        report($sformatf("index %0d, want %0d", beat[IDX_W-1:0], want.index));
      if (beat[IDX_W +: SAMPLE_W] !== want.lo)
        report($sformatf("cell %0d min %h, want %h", want.index,
                         beat[IDX_W +: SAMPLE_W], want.lo));
      if (beat[IDX_W+SAMPLE_W +: SAMPLE_W] !== want.hi)
        report($sformatf("cell %0d max %h, want %h", want.index,
                         beat[IDX_W+SAMPLE_W +: SAMPLE_W], want.hi));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata;   // [15:0] sample
  logic                 in_tuser;   // [0] first_voxel
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;  // [14:0] cell_index, [30:15] cell_min,
                                    // [46:31] cell_max, [47] zero

  cell_range_tracker cells = new();
  int unsigned       voxels_sent;
  int unsigned       size_writes;
  int unsigned       vol_cur;
  logic              hold_req;

  volume_cell_min_max DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Idle percentages: sender light / receiver heavy, then swapped, then none.
  function automatic int send_idle_pct();
    if (voxels_sent < 450) return 8;
    if (voxels_sent < 950) return 63;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (voxels_sent < 450) return 63;
    if (voxels_sent < 950) return 8;
    return 0;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with in_tvalid left high.
  task automatic send_voxel(input sample_t s, input logic first);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cells.note_voxel(s, first);
    voxels_sent++;
    @(negedge clk);
  endtask

  task automatic stream_voxels(input int unsigned n, input bit restart);
    for (int unsigned i = 0; i < n; i++)
      send_voxel(pick_sample(), (i == 0 && restart) || ($urandom_range(0, 299) == 0));
  endtask

  // Drop the input and wait until every cell is out and the pipe has drained.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (cells.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input cfg_reg_t r, input logic [SIZE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cells.set_size(r, v);
    size_writes++;
    @(negedge clk);
  endtask

  task automatic configure(input logic [SIZE_W-1:0] vx, vy, vz);
    settle();
    write_size(REG_SIZE_X, vx);
    write_size(REG_SIZE_Y, vy);
    write_size(REG_SIZE_Z, vz);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold on request.
  initial begin : ready_gen
    int unsigned held;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   <= 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) cells.check_cell(out_tdata);
  end

  initial begin
    #2_000_000;
    $display("volume_cell_min_max: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned       target, kind, ex, ey, ez, zmax;
    logic [SIZE_W-1:0] vx, vy, vz;
    sample_t           corner [6];
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SIZE_X;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    hold_req    = 1'b0;
    voxels_sent = 0;
    size_writes = 0;
    corner[0] = 16'h0000;
    corner[1] = 16'hFFFF;
    corner[2] = 16'h8000;
    corner[3] = 16'h7FFF;
    corner[4] = 16'h5555;
    corner[5] = 16'hAAAA;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero sizes act as one voxel: every beat is a whole cell.
    configure('0, '0, '0);
    for (int i = 0; i < 6; i++) send_voxel(corner[i], i[0]);

    // Stop a deep column part way, then shrink depth below the position.
    configure(1, 1, 18);
    stream_voxels(16, 1'b1);
    configure(1, 1, 3);
    for (int i = 0; i < 3; i++) send_voxel(pick_sample(), 1'b0);

    target = voxels_sent + RANDOM_BEATS;

    // Full-width row with oversize value; hold the receiver to fill the pipe.
    configure(10'd1023, '0, '0);
    hold_req <= 1'b1;
    stream_voxels(512, 1'b1);
    configure(1, 512, 1);
    stream_voxels(48, 1'b1);
    configure('0, 1, 700);
    stream_voxels(48, 1'b1);
    vol_cur = 40;

    while (voxels_sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
        // carry on with the same geometry, no restart
        stream_voxels($urandom_range(1, 2 * vol_cur), 1'b0);
      end else begin
        vx = $urandom_range(1, 40);
        vy = $urandom_range(1, 20);
        if ($urandom_range(0, 7) == 0) vx = '0;
        if ($urandom_range(0, 7) == 0) vy = '0;
        ex = (vx == 0) ? 1 : vx;
        ey = (vy == 0) ? 1 : vy;
        zmax = 120 / (ex * ey);
        if (zmax < 1) zmax = 1;
        if (zmax > 40) zmax = 40;
        vz = $urandom_range(1, zmax);
        if ($urandom_range(0, 7) == 0) vz = '0;
        ez = (vz == 0) ? 1 : vz;
        vol_cur = ex * ey * ez;
        configure(vx, vy, vz);
        if (kind == 2) stream_voxels($urandom_range(1, vol_cur), 1'b1);
        else stream_voxels(vol_cur * $urandom_range(1, 2), 1'b1);
      end
    end

    settle();
    repeat (8) @(negedge clk);
    $display("Run covered %0d voxel beats, %0d cell beats checked, %0d size writes.",
             voxels_sent, cells.cells_seen, size_writes);
    $display("Geometries from one voxel to full 512-voxel axes, partial edge cells.");
    if (cells.errors == 0) begin
      $display("volume_cell_min_max: match");
    end else begin
      $display("volume_cell_min_max: mismatch");
    end
    $finish;
  end

endmodule
